// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Overlapping implication, checked on the rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== sv/sht_pkg.sv =====
// Package with types, constants and codes of the string key hash table.
package sht_pkg;
    localparam int TABLE_SIZE_DEF = 1024;
    localparam int KEY_CHARS_DEF  = 15;
    localparam int TYPE_CHARS     = 9;
    localparam int SLOT_W         = 10;
    localparam logic [63:0] HASH_SEED = 64'd5381;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    localparam logic OP_SEARCH = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [7:0]  type_high;
        logic [63:0] type_low;
        logic [55:0] key_high;
        logic [63:0] key_low;
        logic        occupied;
    } entry_t;

    typedef struct packed {
        logic [7:0]  found_type_high;
        logic [63:0] found_type_low;
        logic [9:0]  slot_index;
        logic [1:0]  status;
    } result_t;
endpackage

// ===== sv/sht_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== sv/sht_hash.sv =====
// Key trimming and serial hash unit, one character per cycle.
module sht_hash #(
    parameter int TABLE_SIZE = sht_pkg::TABLE_SIZE_DEF,
    parameter int KEY_CHARS  = sht_pkg::KEY_CHARS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [119:0]                  key_in,
    output logic [119:0]                  key,
    output logic                          done,
    output logic [$clog2(TABLE_SIZE)-1:0] hash
);
    import sht_pkg::*;

    localparam int HW = $clog2(TABLE_SIZE);
    localparam int WW = HW + 9;

    logic [119:0]  key_reg, key_next, key_canon;
    logic [HW-1:0] hash_reg, hash_next;
    logic [3:0]    cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic [127:0]  key_pad;
    logic [7:0]    chr;
    logic [WW-1:0] mix;

    // Bytes after the first zero or past the length limit are cleared.
    always_comb
    begin
        logic keep;
        keep = 1'b1;
        key_canon = '0;
        for (int b = 0; b < 15; b++)
        begin
            keep = keep && (key_in[8*b +: 8] != 8'h00) && (b < KEY_CHARS);
            if (keep)
            begin
                key_canon[8*b +: 8] = key_in[8*b +: 8];
            end
        end
    end

    assign key_pad = {8'h00, key_reg};
    assign chr     = key_pad[{cnt_reg, 3'b000} +: 8];
    assign mix     = (WW'(hash_reg) << 4) + WW'(hash_reg) + WW'(chr);
    assign done    = run_reg && (chr == 8'h00);

    always_comb
    begin
        key_next  = key_reg;
        hash_next = hash_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        if (start)
        begin
            key_next  = key_canon;
            hash_next = HASH_SEED[HW-1:0];
            cnt_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (chr == 8'h00)
            begin
                run_next = 1'b0;
            end
            else
            begin
                hash_next = mix[HW-1:0];
                cnt_next  = cnt_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        hash_reg <= hash_next;
    end

    assign key  = key_reg;
    assign hash = hash_reg;
endmodule

// ===== sv/string_key_hash_table.sv =====
// Top level of the string key hash table with linear probing.
// Usage:
// The block takes one request transaction on the s_axis channel. tuser
// selects the operation (0 search, 1 insert); tdata carries the key and,
// for inserts, the type name. Each request yields exactly one result
// transaction on the m_axis channel with a status, the slot and the type.
// Flow: the request is accepted, the hash unit takes the key character
// by character, each probe reads the memory and then compares (ST_READ,
// ST_CHECK), and the result is handed to the output register. A probe needs
// both states because the table memory has a registered read port.
// A request is handled one at a time; the next is accepted once the
// result has moved to the output register.
// Reset: after rst_n rises the block sweeps the table memory, one slot per
// cycle, for TABLE_SIZE cycles, and holds s_axis_tready low meanwhile.
// Stall: if m_axis_tready stays low, the result stays in the output
// register and the next result waits in the done state until it drains.
// TABLE_SIZE must be a power of two; the probe slot is the low hash bits.
module string_key_hash_table #(
    parameter int TABLE_SIZE = sht_pkg::TABLE_SIZE_DEF,
    parameter int KEY_CHARS  = sht_pkg::KEY_CHARS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key_low[63:0], key_high[119:64], type_low[183:120], type_high[191:184]
    input  logic [191:0] s_axis_tdata,
    // operation[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // status[1:0], slot_index[11:2], found_type_low[75:12],
    // found_type_high[83:76], zero[87:84]
    output logic [87:0]  m_axis_tdata
);
    import sht_pkg::*;

    localparam int IW = $clog2(TABLE_SIZE);
    localparam int EW = $bits(entry_t);
    localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);

    state_t        state_reg, state_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [IW-1:0] addr_reg, addr_next;
    logic [IW-1:0] probe_reg, probe_next;
    logic          op_reg, op_next;
    logic [71:0]   type_reg, type_next, type_canon;
    result_t       res_reg, res_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic          accept, hash_done;
    logic [119:0]  hash_key;
    logic [IW-1:0] hash_val;
    logic          we, re;
    logic [IW-1:0] waddr;
    entry_t        wentry, rentry;
    logic [EW-1:0] rdata;
    logic          out_free;

    sht_hash #(
        .TABLE_SIZE(TABLE_SIZE),
        .KEY_CHARS (KEY_CHARS)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept),
        .key_in(s_axis_tdata[119:0]),
        .key   (hash_key),
        .done  (hash_done),
        .hash  (hash_val)
    );

    sht_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_SIZE)
    ) u_ram (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wentry),
        .re   (re),
        .raddr(addr_reg),
        .rdata(rdata)
    );

    assign rentry   = entry_t'(rdata);
    assign out_free = !out_valid_reg || m_axis_tready;

    // The type name ends at its first zero byte.
    always_comb
    begin
        logic keep;
        keep = 1'b1;
        type_canon = '0;
        for (int b = 0; b < TYPE_CHARS; b++)
        begin
            keep = keep && (s_axis_tdata[120 + 8*b +: 8] != 8'h00);
            if (keep)
            begin
                type_canon[8*b +: 8] = s_axis_tdata[120 + 8*b +: 8];
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                if (hash_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK:
            begin
                // A probe ends the walk on a free slot, a search hit or once every slot has been probed.
                if (!rentry.occupied || probe_reg == LAST ||
                    (op_reg == OP_SEARCH && rentry.key_low == hash_key[63:0] &&
                     rentry.key_high == hash_key[119:64]))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        re            = 1'b0;
        we            = 1'b0;
        waddr         = addr_reg;
        wentry        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
            end
            ST_IDLE:  s_axis_tready = 1'b1;
            ST_READ:  re = 1'b1;
            ST_CHECK:
            begin
                if (op_reg == OP_INSERT && !rentry.occupied)
                begin
                    we               = 1'b1;
                    wentry.occupied  = 1'b1;
                    wentry.key_low   = hash_key[63:0];
                    wentry.key_high  = hash_key[119:64];
                    wentry.type_low  = type_reg[63:0];
                    wentry.type_high = type_reg[71:64];
                end
            end
            default:  s_axis_tready = 1'b0;
        endcase
    end

    assign accept = s_axis_tvalid && s_axis_tready;

    // Datapath registers.
    always_comb
    begin
        clr_next       = clr_reg;
        addr_next      = addr_reg;
        probe_next     = probe_reg;
        op_next        = op_reg;
        type_next      = type_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_CLEAR: clr_next = clr_reg + 1'b1;
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next   = s_axis_tuser;
                    type_next = type_canon;
                end
            end
            ST_HASH:
            begin
                addr_next  = hash_val;
                probe_next = '0;
            end
            ST_CHECK:
            begin
                res_next = '0;
                addr_next  = addr_reg + 1'b1;
                probe_next = probe_reg + 1'b1;
                if (op_reg == OP_INSERT)
                begin
                    res_next.status = STATUS_FULL;
                    if (!rentry.occupied)
                    begin
                        res_next.status     = STATUS_OK;
                        res_next.slot_index = SLOT_W'(addr_reg);
                    end
                end
                else
                begin
                    res_next.status = STATUS_NOT_FOUND;
                    if (rentry.occupied && rentry.key_low == hash_key[63:0] &&
                        rentry.key_high == hash_key[119:64])
                    begin
                        res_next.status          = STATUS_OK;
                        res_next.slot_index      = SLOT_W'(addr_reg);
                        res_next.found_type_low  = rentry.type_low;
                        res_next.found_type_high = rentry.type_high;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                end
            end
            default:  clr_next = clr_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        probe_reg <= probe_next;
        op_reg    <= op_next;
        type_reg  <= type_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_reg};
endmodule

// ===== sv/sht_checker.sv =====
// Port-level checker for the string key hash table, bound to the top level.
`include "assert_macros.svh"
module sht_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [87:0]  m_axis_tdata
);
    `ASSERT_NXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `ASSERT_IMP(a_status_code, clk, rst_n, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
    `ASSERT_IMP(a_miss_zero, clk, rst_n, m_axis_tvalid && m_axis_tdata[1:0] != 2'd0, m_axis_tdata[87:2] == '0)
    `ASSERT_NXT(a_one_at_a_time, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule

bind string_key_hash_table sht_checker u_sht_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

// ===== dv/tb_string_key_hash_table.sv =====
// Self-checking testbench for the string key hash table with linear probing.
`timescale 1ns / 100ps

module tb_string_key_hash_table;
    import sht_pkg::*;

    localparam int SLOTS         = 1024;
    localparam int POOL_KEYS     = 64;
    localparam int RANDOM_ITEMS  = 400;
    localparam int QUIET_TAIL    = 200;
    localparam int IDLE_LIMIT    = 20000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 20;

    // Scoreboard: holds a mirror of the table, works out the expected result
    // of every accepted request, and compares the results in order.
    class hash_table_scoreboard;
        bit          occupied [SLOTS];
        logic [63:0] key_lo [SLOTS];
        logic [55:0] key_hi [SLOTS];
        logic [63:0] type_lo [SLOTS];
        logic [7:0]  type_hi [SLOTS];
        result_t     pending_results [$];
        int          errors;
        int          used_slots;
        int          inserts;
        int          searches;
        int          hits;
        int          full_hits;

        // The key ends at its first zero byte; later bytes are dropped.
        function automatic logic [63:0] canon_key(input logic [119:0] raw,
                                                  output logic [119:0] clean);
            logic [63:0] h;
            logic [7:0]  c;
            bit          ended;
            h = HASH_SEED;
            clean = '0;
            ended = 0;
            for (int n = 0; n < 15; n++)
            begin
                c = raw[8*n +: 8];
                if (c == 8'd0)
                    ended = 1;
                if (!ended)
                begin
                    clean[8*n +: 8] = c;
                    h = (h << 4) + h + {56'd0, c};
                end
            end
            return h;
        endfunction

        function automatic logic [71:0] canon_type(input logic [71:0] raw);
            logic [71:0] clean;
            bit          ended;
            clean = '0;
            ended = 0;
            for (int n = 0; n < TYPE_CHARS; n++)
            begin
                if (raw[8*n +: 8] == 8'd0)
                    ended = 1;
                if (!ended)
                    clean[8*n +: 8] = raw[8*n +: 8];
            end
            return clean;
        endfunction

        function void note_request(input logic operation, input logic [191:0] data);
            logic [119:0] key;
            logic [71:0]  tname;
            logic [63:0]  h;
            logic [9:0]   j;
            result_t      r;
            h = canon_key(data[119:0], key);
            r = '0;
            r.status = STATUS_NOT_FOUND;
            if (operation == OP_INSERT)
            begin
                inserts++;
                tname = canon_type(data[191:120]);
                r.status = STATUS_FULL;
                for (int i = 0; i < SLOTS; i++)
                begin
                    j = h[9:0] + i[9:0];
                    if (!occupied[j])
                    begin
                        occupied[j] = 1;
                        key_lo[j]   = key[63:0];
                        key_hi[j]   = key[119:64];
                        type_lo[j]  = tname[63:0];
                        type_hi[j]  = tname[71:64];
                        used_slots++;
                        r.status     = STATUS_OK;
                        r.slot_index = j;
                        break;
                    end
                end
                if (r.status == STATUS_FULL)
                    full_hits++;
            end
            else
            begin
                searches++;
                for (int i = 0; i < SLOTS; i++)
                begin
                    j = h[9:0] + i[9:0];
                    if (!occupied[j])
                        break;
                    if (key_lo[j] == key[63:0] && key_hi[j] == key[119:64])
                    begin
                        r.status          = STATUS_OK;
                        r.slot_index      = j;
                        r.found_type_low  = type_lo[j];
                        r.found_type_high = type_hi[j];
                        hits++;
                        break;
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        function void report(input string what, input logic [87:0] got, input result_t exp);
            errors++;
            if (errors <= 10)
                $display("%0t: %s mismatch: expected status=%0d slot=%0d type=%h_%h, got %h",
                         $realtime, what, exp.status, exp.slot_index,
                         exp.found_type_high, exp.found_type_low, got);
        endfunction

        function void check_result(input logic [87:0] data);
            result_t exp;
            if (pending_results.size() == 0)
            begin
                exp = '0;
                report("unexpected result", data, exp);
                return;
            end
            exp = pending_results.pop_front();
            if (data[1:0] !== exp.status)
                report("status", data, exp);
            if (data[11:2] !== exp.slot_index)
                report("slot_index", data, exp);
            if (data[75:12] !== exp.found_type_low)
                report("found_type_low", data, exp);
            if (data[83:76] !== exp.found_type_high)
                report("found_type_high", data, exp);
            if (data[87:84] !== 4'd0)
                report("padding", data, exp);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;

    hash_table_scoreboard table_model;
    logic [119:0] key_pool [POOL_KEYS];
    int           key_pool_len [POOL_KEYS];
    bit           quiet;
    bit           long_hold_request;
    int           idle_cycles;

    string_key_hash_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Both handshakes are sampled at the rising edge, where the inputs
    // driven at the falling edge are settled.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                table_model.note_request(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                table_model.check_result(m_axis_tdata);
        end
    end

    // Watchdog: counts cycles in which no transaction moves on either side.
    // The limit covers the clearing sweep after reset, a probe across the
    // whole table and the long receiver hold-off several times over.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("string_key_hash_table regression: fail");
            $finish;
        end
    end

    // Receiver: random stall bursts, one long hold-off on request, and no new
    // stalls once the quiet tail begins.
    initial
    begin : receiver
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_request)
            begin
                long_hold_request = 0;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                hold = $urandom_range(0, 3);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Builds a key of the given length with nonzero characters. Where the
    // key is short, the bytes after the terminator may hold junk that the
    // block must ignore.
    function automatic logic [119:0] make_key(input int len, input bit junk);
        logic [119:0] k;
        for (int n = 0; n < 15; n++)
        begin
            if (n < len)
                k[8*n +: 8] = 8'($urandom_range(1, 255));
            else if (n == len || !junk)
                k[8*n +: 8] = 8'd0;
            else
                k[8*n +: 8] = 8'($urandom_range(0, 255));
        end
        return k;
    endfunction

    function automatic logic [71:0] make_type(input bit junk);
        logic [71:0] t;
        int          len;
        len = $urandom_range(0, TYPE_CHARS);
        for (int n = 0; n < TYPE_CHARS; n++)
        begin
            if (n < len)
                t[8*n +: 8] = 8'($urandom_range(1, 255));
            else if (n == len || !junk)
                t[8*n +: 8] = 8'd0;
            else
                t[8*n +: 8] = 8'($urandom_range(0, 255));
        end
        return t;
    endfunction

    // Offers one request at the current falling edge and returns at the
    // falling edge after it was accepted, with an optional gap before it.
    task automatic send_request(input logic operation, input logic [119:0] key,
                                input logic [71:0] tname);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= operation;
        s_axis_tdata  <= {tname, key};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    // Pool key with junk after its terminator now and then; the block must
    // still treat it as the same identifier.
    function automatic logic [119:0] pool_key(input int idx);
        logic [119:0] k;
        int           len;
        k = key_pool[idx];
        len = key_pool_len[idx];
        if (len < 14 && $urandom_range(0, 1))
            for (int n = len + 1; n < 15; n++)
                k[8*n +: 8] = 8'($urandom_range(0, 255));
        return k;
    endfunction

    initial
    begin : stimulus
        logic [119:0] k;
        logic [119:0] absent;
        int           guard;
        table_model = new();
        quiet = 0;
        long_hold_request = 0;
        idle_cycles = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = OP_SEARCH;
        s_axis_tdata  = '0;
        rst_n = 1'b0;
        for (int p = 0; p < POOL_KEYS; p++)
        begin
            key_pool_len[p] = (p < 8) ? 15 : $urandom_range(0, 15);
            key_pool[p] = make_key(key_pool_len[p], 0);
        end
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. The empty key, with and without junk behind it.
        send_request(OP_SEARCH, '0, '0);
        send_request(OP_INSERT, '0, {8'hFF, 64'hFFFF_FFFF_FFFF_FFFF});
        send_request(OP_SEARCH, {56'hFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FF00}, '0);
        // Full length key of all ones, then a search that finds it.
        send_request(OP_INSERT, {120{1'b1}}, {8'h41, 64'h0042_4342_4144_4546});
        send_request(OP_SEARCH, {120{1'b1}}, {72{1'b1}});
        // Duplicate insert: the search must return the first copy.
        k = make_key(5, 0);
        send_request(OP_INSERT, k, 72'h00_0000_0000_0074_6E69);
        send_request(OP_INSERT, k, 72'h00_0000_0000_6C61_6572);
        send_request(OP_SEARCH, k, '0);
        // Junk after the terminator of key and type.
        send_request(OP_INSERT, {104'h34_5678_9ABC_DEF0_1122_3344_5566, 8'd0, 8'h61},
                     {8'h99, 64'h7788_0066_5544_3322});
        send_request(OP_SEARCH, 120'h61, '0);
        // A miss on a short key and on a long key.
        send_request(OP_SEARCH, make_key(3, 0), '0);
        send_request(OP_SEARCH, make_key(15, 0), '0);
        // One-character keys with the extreme byte values.
        send_request(OP_INSERT, 120'h01, 72'h01);
        send_request(OP_INSERT, 120'hFF, {8'h80, 64'h8080_8080_8080_8080});
        send_request(OP_SEARCH, 120'h01, '0);
        send_request(OP_SEARCH, 120'hFF, '0);

        // Random part: mostly identifiers from a small pool so that searches
        // hit and duplicates pile up, some fresh identifiers that miss.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 300)
                long_hold_request = 1;
            if ($urandom_range(0, 9) < 7)
                k = pool_key($urandom_range(0, POOL_KEYS - 1));
            else
                k = make_key($urandom_range(0, 15), $urandom_range(0, 1));
            send_request(($urandom_range(0, 99) < 55) ? OP_INSERT : OP_SEARCH, k,
                         make_type($urandom_range(0, 1)));
        end

        // Fill the table with fresh keys and some searches mixed in, then
        // probe the full table: inserts fail, misses scan every slot.
        guard = 0;
        while (table_model.used_slots < SLOTS && guard < 4 * SLOTS)
        begin
            guard++;
            if (SLOTS - table_model.used_slots < QUIET_TAIL)
                quiet = 1;
            if ($urandom_range(0, 7) == 0)
                send_request(OP_SEARCH, pool_key($urandom_range(0, POOL_KEYS - 1)), '0);
            else
                send_request(OP_INSERT, make_key($urandom_range(1, 15), 1),
                             make_type(1));
        end
        quiet = 1;
        absent = {8'd0, {14{8'h7E}}};
        for (int n = 0; n < 3; n++)
        begin
            send_request(OP_INSERT, make_key(4, 0), make_type(0));
            send_request(OP_SEARCH, absent, '0);
            send_request(OP_SEARCH, pool_key($urandom_range(0, POOL_KEYS - 1)), '0);
        end
        s_axis_tvalid <= 1'b0;

        guard = 0;
        while (table_model.pending_results.size() != 0 && guard < 10 * IDLE_LIMIT)
        begin
            guard++;
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d inserts and %0d searches: %0d search hits, %0d inserts on a full table.",
                 table_model.inserts, table_model.searches, table_model.hits,
                 table_model.full_hits);
        $display("Slots in use at the end: %0d of %0d; mismatches: %0d.",
                 table_model.used_slots, SLOTS, table_model.errors);
        if (table_model.errors == 0 && table_model.pending_results.size() == 0)
            $display("string_key_hash_table regression: pass");
        else
            $display("string_key_hash_table regression: fail");
        $finish;
    end
endmodule
